// ----- rtl/core/dctm_pkg.sv -----
// Shared types, constants and elaboration-time table builders for the drive/clip/tone stage.
// No dependencies; used by dctm_mul and drive_clip_tone_mix_stage.
package dctm_pkg;

  localparam int DEF_SAMPLE_RATE_HZ   = 48000;
  localparam int DEF_LOW_CUTOFF_HZ    = 200;
  localparam int DEF_HIGH_CUTOFF_HZ   = 2000;
  localparam int DEF_TANH_TABLE_DEPTH = 256;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int WET_W    = 15;
  localparam int CFG_IDX_W = 3;

  // shared multiplier geometry
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int TANH_W   = 21;
  localparam int CLIP_EDGE = 1572864;   // 1.5 in Q20, 3 * 2^19
  localparam int UNITY_Q20 = 1048576;
  localparam int SAT_MAX  = 8388607;
  localparam int SAT_MIN  = -8388608;
  localparam longint unsigned TWO_PI_Q24 = 64'd105414357;
  localparam int RECIP3_16   = 43691;    // floor(v/3) = (v*43691)>>17 for v < 2^16
  localparam int RECIP3_23   = 2796203;  // floor(v/3) = (v*2796203)>>23 for v < 2^23

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN  = 3'd0,
    REG_DRIVE_GAIN  = 3'd1,
    REG_CLIP_ENABLE = 3'd2,
    REG_BASS_GAIN   = 3'd3,
    REG_TREBLE_GAIN = 3'd4,
    REG_WET_MIX     = 3'd5,
    REG_OUTPUT_GAIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       left_present;
    logic                       right_present;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_word_t;

  // shift-and-subtract quotient, evaluated at elaboration only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series of exp in Q24, evaluated at elaboration only
  function automatic longint unsigned exp_q24(input longint unsigned z);
    longint unsigned sum;
    longint unsigned term;
    bit              done;
    sum  = 64'd1 << 24;
    term = 64'd1 << 24;
    done = 1'b0;
    for (int k = 1; k < 80; k++) begin
      if (!done) begin
        term = udiv((term * z) >> 24, longint'(k));
        if (term == 0) done = 1'b1;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic longint unsigned make_alpha(input int fc, input int fs);
    longint unsigned z;
    longint unsigned e;
    z = udiv(TWO_PI_Q24 * longint'(fc), longint'(fs));
    e = exp_q24(z);
    return udiv((64'd1 << 54) + e / 2, e);
  endfunction

  function automatic logic [TANH_W-1:0] tanh_entry(input int i, input int depth);
    longint unsigned y;
    longint unsigned e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned v;
    y   = udiv((64'd3 * longint'(i)) << 24, longint'(depth));
    e   = exp_q24(y);
    num = e - (64'd1 << 24);
    den = e + (64'd1 << 24);
    v   = udiv((num << 20) + den / 2, den);
    return v[TANH_W-1:0];
  endfunction

  // shift right rounding half away from zero
  function automatic logic signed [MUL_P_W-1:0] rshr(input logic signed [MUL_P_W-1:0] v,
                                                     input int sh);
    logic signed [MUL_P_W-1:0] half;
    logic signed [MUL_P_W-1:0] adj;
    half = MUL_P_W'(1) <<< (sh - 1);
    adj  = v + half - (v[MUL_P_W-1] ? MUL_P_W'(1) : MUL_P_W'(0));
    return adj >>> sh;
  endfunction

endpackage

// ----- rtl/core/dctm_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on dctm_pkg for operand widths.
module dctm_mul
  import dctm_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [MUL_P_W-1:0] mul_p
);

  logic signed [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = p_r;

endmodule

// ----- rtl/core/drive_clip_tone_mix_stage.sv -----
// Drive, tanh soft clip, three-band tone and dry/wet mix for one stereo frame per word.
// Both channels run in turn through one sequencer; the clip path adds table steps per
//   channel, and an output stall holds the finished frame in ST_DONE;
//   no new word taken while a frame is in work.
// Every multiply goes through one shared multiplier, issue and consume on alternate cycles.
// Reset (rst_n low, synchronous) restores register defaults and zeroes filter state.
// Depends on dctm_pkg and dctm_mul.
module drive_clip_tone_mix_stage
  import dctm_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ   = DEF_SAMPLE_RATE_HZ,
  parameter int LOW_CUTOFF_HZ    = DEF_LOW_CUTOFF_HZ,
  parameter int HIGH_CUTOFF_HZ   = DEF_HIGH_CUTOFF_HZ,
  parameter int TANH_TABLE_DEPTH = DEF_TANH_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata
);

  // filter coefficients, unsigned Q30
  localparam logic [31:0] ALPHA_L = 32'(make_alpha(LOW_CUTOFF_HZ, SAMPLE_RATE_HZ));
  localparam logic [31:0] ALPHA_H = 32'(make_alpha(HIGH_CUTOFF_HZ, SAMPLE_RATE_HZ));
  localparam logic [31:0] BETA_L  = 32'(64'd1 << 30) - ALPHA_L;
  localparam logic [31:0] BETA_H  = 32'(64'd1 << 30) - ALPHA_H;

  localparam int IDXW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int POSW = 21 + IDXW;       // |x| * depth
  localparam int VW   = POSW - 19;       // position over 2^19
  localparam int XW   = 30;              // driven sample width
  localparam int YW   = MUL_A_W;         // tone sum / mix width

  typedef enum logic [4:0] {
    ST_IDLE, M_TRIM, W_TRIM, M_DRV, W_DRV, M_POS, W_POS, M_IDX, W_IDX,
    M_FR, W_FR, M_Q, W_Q, M_LA, W_LA, M_LB, W_LB, M_HA, W_HA, M_HB, W_HB,
    M_BASS, W_BASS, M_TRE, W_TRE, M_WET, W_WET, M_OUT, W_OUT, ST_DONE
  } state_t;

  // tanh table, built at elaboration
  logic [TANH_W-1:0] tanh_tab [TANH_TABLE_DEPTH+1];
  for (genvar g = 0; g <= TANH_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [TANH_W-1:0] ENTRY = tanh_entry(g, TANH_TABLE_DEPTH);
    assign tanh_tab[g] = ENTRY;
  end

  // configuration
  logic [GAIN_W-1:0] input_gain_r, drive_gain_r, bass_gain_r, treble_gain_r, output_gain_r;
  logic              clip_enable_r;
  logic [WET_W-1:0]  wet_mix_r;

  // control and datapath
  state_t                       state_r, state_nxt;
  logic                         ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0]   dry_r [2];
  logic signed [SAMPLE_W-1:0]   dry_nxt [2];
  logic signed [XW-1:0]         x_r, x_nxt;
  logic                         neg_r, neg_nxt;
  logic [POSW-1:0]              pos_r, pos_nxt;
  logic [IDXW-1:0]              idx_r, idx_nxt;
  logic [20:0]                  fr_r, fr_nxt;
  logic [TANH_W-1:0]            lo_r, lo_nxt;
  logic [22:0]                  v2_r, v2_nxt;
  logic signed [MUL_P_W-1:0]    acc_r, acc_nxt;
  logic signed [YW-1:0]         y_r, y_nxt;
  logic signed [31:0]           low_r [2];
  logic signed [31:0]           high_r [2];
  logic signed [31:0]           low_nxt [2];
  logic signed [31:0]           high_nxt [2];
  logic signed [SAMPLE_W-1:0]   res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_word_t                    out_data_r;

  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [MUL_P_W-1:0]    mul_p;

  dctm_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // effective drive and mix, clamped to range
  logic [GAIN_W-1:0] drive_eff;
  logic [WET_W-1:0]  wet_eff;
  logic              clip_on;
  assign drive_eff = (drive_gain_r > GAIN_W'(32768)) ? GAIN_W'(32768) : drive_gain_r;
  assign wet_eff   = (wet_mix_r > WET_W'(16384)) ? WET_W'(16384) : wet_mix_r;
  assign clip_on   = clip_enable_r && (drive_eff > GAIN_W'(16384));

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic signed [SAMPLE_W-1:0] dry_cur;
  logic signed [31:0]         ls_cur, hs_cur;
  logic [20:0]                mag;
  logic [IDXW-1:0]            idx_calc, hi_idx;
  logic [IDXW+1:0]            idx3;
  logic [TANH_W-1:0]          lo_val, hi_val;
  logic signed [MUL_P_W-1:0]  rnd12, rnd14, rnd30, t_fr;
  logic [TANH_W-1:0]          val;
  logic                       at_end;

  always_comb begin
    dry_cur  = dry_r[ch_r];
    ls_cur   = low_r[ch_r];
    hs_cur   = high_r[ch_r];
    mag      = x_r[XW-1] ? 21'(-x_r) : 21'(x_r);
    idx_calc = mul_p[17 +: IDXW];
    idx3     = ({2'b00, idx_calc} << 1) + {2'b00, idx_calc};
    at_end   = (idx_r >= IDXW'(TANH_TABLE_DEPTH));
    hi_idx   = at_end ? idx_r : idx_r + IDXW'(1);
    lo_val   = tanh_tab[idx_r];
    hi_val   = tanh_tab[hi_idx];
    rnd12    = rshr(mul_p, 12);
    rnd14    = rshr(mul_p, 14);
    rnd30    = rshr(acc_r + mul_p, 30);
    t_fr     = mul_p + MUL_P_W'(CLIP_EDGE / 2);
    val      = lo_r + mul_p[23 +: TANH_W];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      M_TRIM: begin
        mul_a = MUL_A_W'(dry_cur);
        mul_b = MUL_B_W'({1'b0, input_gain_r});
      end
      M_DRV: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = MUL_B_W'({1'b0, drive_eff});
      end
      M_POS: begin
        mul_a = MUL_A_W'({1'b0, mag});
        mul_b = MUL_B_W'(TANH_TABLE_DEPTH);
      end
      M_IDX: begin
        mul_a = MUL_A_W'({1'b0, pos_r[19 +: VW]});
        mul_b = MUL_B_W'(RECIP3_16);
      end
      M_FR: begin
        mul_a = MUL_A_W'({1'b0, hi_val - lo_val});
        mul_b = MUL_B_W'({1'b0, fr_r});
      end
      M_Q: begin
        mul_a = MUL_A_W'({1'b0, v2_r});
        mul_b = MUL_B_W'(RECIP3_23);
      end
      M_LA: begin
        mul_a = MUL_A_W'(ls_cur);
        mul_b = $signed(ALPHA_L);
      end
      M_LB: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = $signed(BETA_L);
      end
      M_HA: begin
        mul_a = MUL_A_W'(hs_cur);
        mul_b = $signed(ALPHA_H);
      end
      M_HB: begin
        mul_a = MUL_A_W'(x_r);
        mul_b = $signed(BETA_H);
      end
      M_BASS: begin
        mul_a = MUL_A_W'(ls_cur);
        mul_b = MUL_B_W'({1'b0, bass_gain_r});
      end
      M_TRE: begin
        mul_a = MUL_A_W'(x_r) - MUL_A_W'(hs_cur);
        mul_b = MUL_B_W'({1'b0, treble_gain_r});
      end
      M_WET: begin
        mul_a = y_r - MUL_A_W'(dry_cur);
        mul_b = MUL_B_W'({1'b0, wet_eff});
      end
      M_OUT: begin
        mul_a = y_r;
        mul_b = MUL_B_W'({1'b0, output_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer: M_* issues a multiply, W_* takes the product in the cycle after
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    dry_nxt       = dry_r;
    x_nxt         = x_r;
    neg_nxt       = neg_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    fr_nxt        = fr_r;
    lo_nxt        = lo_r;
    v2_nxt        = v2_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // substitute a missing channel with the other one, zero if both missing
          dry_nxt[0] = in_data.left_present  ? in_data.left_sample :
                       in_data.right_present ? in_data.right_sample : '0;
          dry_nxt[1] = in_data.right_present ? in_data.right_sample :
                       in_data.left_present  ? in_data.left_sample  : '0;
          ch_nxt     = 1'b0;
          state_nxt  = M_TRIM;
        end
      end
      M_TRIM: state_nxt = W_TRIM;
      W_TRIM: begin
        x_nxt     = XW'(rnd12);
        state_nxt = M_DRV;
      end
      M_DRV: state_nxt = W_DRV;
      W_DRV: begin
        x_nxt     = XW'(rnd14);
        state_nxt = clip_on ? M_POS : M_LA;
      end
      M_POS: begin
        // beyond 1.5 saturate to unity, otherwise go through the table
        if (x_r > XW'(CLIP_EDGE)) begin
          x_nxt     = XW'(UNITY_Q20);
          state_nxt = M_LA;
        end else if (x_r < -XW'(CLIP_EDGE)) begin
          x_nxt     = -XW'(UNITY_Q20);
          state_nxt = M_LA;
        end else begin
          neg_nxt   = x_r[XW-1];
          state_nxt = W_POS;
        end
      end
      W_POS: begin
        pos_nxt   = mul_p[POSW-1:0];
        state_nxt = M_IDX;
      end
      M_IDX: state_nxt = W_IDX;
      W_IDX: begin
        idx_nxt   = idx_calc;
        fr_nxt    = 21'(pos_r - (POSW'(idx3) << 19));
        state_nxt = M_FR;
      end
      M_FR: begin
        lo_nxt    = lo_val;
        state_nxt = W_FR;
      end
      W_FR: begin
        v2_nxt    = t_fr[19 +: 23];
        state_nxt = M_Q;
      end
      M_Q: state_nxt = W_Q;
      W_Q: begin
        x_nxt     = neg_r ? -XW'(val) : XW'(val);
        state_nxt = M_LA;
      end
      M_LA: state_nxt = W_LA;
      W_LA: begin
        acc_nxt   = mul_p;
        state_nxt = M_LB;
      end
      M_LB: state_nxt = W_LB;
      W_LB: begin
        low_nxt[ch_r] = 32'(rnd30);
        state_nxt     = M_HA;
      end
      M_HA: state_nxt = W_HA;
      W_HA: begin
        acc_nxt   = mul_p;
        state_nxt = M_HB;
      end
      M_HB: state_nxt = W_HB;
      W_HB: begin
        high_nxt[ch_r] = 32'(rnd30);
        state_nxt      = M_BASS;
      end
      M_BASS: state_nxt = W_BASS;
      W_BASS: begin
        // bass scaled plus mid band
        y_nxt     = YW'(rnd14) + YW'(hs_cur) - YW'(ls_cur);
        state_nxt = M_TRE;
      end
      M_TRE: state_nxt = W_TRE;
      W_TRE: begin
        y_nxt     = y_r + YW'(rnd14);
        state_nxt = M_WET;
      end
      M_WET: state_nxt = W_WET;
      W_WET: begin
        y_nxt     = YW'(dry_cur) + YW'(rnd14);
        state_nxt = M_OUT;
      end
      M_OUT: state_nxt = W_OUT;
      W_OUT: begin
        if (rnd12 > MUL_P_W'(SAT_MAX))      res_nxt = SAMPLE_W'(SAT_MAX);
        else if (rnd12 < MUL_P_W'(SAT_MIN)) res_nxt = SAMPLE_W'(SAT_MIN);
        else                                res_nxt = SAMPLE_W'(rnd12);
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = M_TRIM;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // right channel result waits here until the output word is loaded
  logic signed [SAMPLE_W-1:0] right_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      ch_r          <= 1'b0;
      input_gain_r  <= GAIN_W'(4096);
      drive_gain_r  <= GAIN_W'(16384);
      clip_enable_r <= 1'b1;
      bass_gain_r   <= GAIN_W'(16384);
      treble_gain_r <= GAIN_W'(16384);
      wet_mix_r     <= WET_W'(16384);
      output_gain_r <= GAIN_W'(4096);
      low_r[0]      <= '0;
      low_r[1]      <= '0;
      high_r[0]     <= '0;
      high_r[1]     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_INPUT_GAIN:  input_gain_r  <= cfg_wdata;
          REG_DRIVE_GAIN:  drive_gain_r  <= cfg_wdata;
          REG_CLIP_ENABLE: clip_enable_r <= cfg_wdata[0];
          REG_BASS_GAIN:   bass_gain_r   <= cfg_wdata;
          REG_TREBLE_GAIN: treble_gain_r <= cfg_wdata;
          REG_WET_MIX:     wet_mix_r     <= cfg_wdata[WET_W-1:0];
          REG_OUTPUT_GAIN: output_gain_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    dry_r  <= dry_nxt;
    x_r    <= x_nxt;
    neg_r  <= neg_nxt;
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    fr_r   <= fr_nxt;
    lo_r   <= lo_nxt;
    v2_r   <= v2_nxt;
    acc_r  <= acc_nxt;
    y_r    <= y_nxt;
    // left result parks in res_r until the right one is done
    if (state_r == W_OUT && !ch_r) res_r <= res_nxt;
    if (state_r == W_OUT && ch_r) right_hold_r <= res_nxt;
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.left_out  <= res_r;
      out_data_r.right_out <= right_hold_r;
    end
  end

endmodule
